### rtl/msw_pkg.sv
`timescale 1ns / 1ps
// Package for the minimum-sum window finder.
// Holds default sizes, register map codes and the stage control struct.
// No dependencies.
package msw_pkg;

    localparam int WINDOW_MAX_DEF  = 1024;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF  = 20;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int LEN_W      = 11;

    localparam logic [APB_ADDR_W-3:0] REG_WINDOW_LEN = 1'b0;
    localparam logic [LEN_W-1:0]      LEN_RESET      = 11'd1;

    // Control that travels with one sample through the pipeline.
    typedef struct packed {
        logic valid;
        logic last;
        logic counted;
        logic sub_en;
        logic full;
    } seq_ctl_t;

endpackage

### rtl/min_sum_window_finder.sv
`timescale 1ns / 1ps
// Top level of the minimum-sum window finder: APB register, stream ports, pipeline.
// Depends on msw_pkg, msw_ram, msw_seq and msw_best.

// Takes one sample per cycle on the input stream, tlast marking the last sample
// of a sequence. The delay line sits in one RAM with one write and one read port,
// so each sample costs one write and at most one read and the block sustains one
// beat per clock. m_tvalid for a sequence rises after its last beat passes the s1
// and s2 registers; the input stalls only while a result is still waiting and the
// next one is ready to leave. Writing window_len restarts the sequence; no clearing
// pass runs after reset, since delay entries are only read after being written.
module min_sum_window_finder #(
    parameter int WINDOW_MAX  = msw_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = msw_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = msw_pkg::COUNT_BITS_DEF,
    localparam int CNT_W = COUNT_BITS + 1,
    localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW_MAX),
    localparam int IN_W  = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((CNT_W + SUM_W + 7) / 8) * 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [msw_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [msw_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [msw_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [IN_W-1:0]                  s_tdata,   // sample
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [OUT_W-1:0]                 m_tdata    // best_start, best_sum
);
    import msw_pkg::*;

    localparam int ADDR_W = $clog2(WINDOW_MAX);
    localparam int EFF_W  = $clog2(WINDOW_MAX + 1);

    logic [LEN_W-1:0]       len_reg, len_next;
    logic                   cfg_we;
    logic [EFF_W-1:0]       eff_len;
    logic                   advance;
    logic                   accept;
    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic [SAMPLE_BITS-1:0] ram_wdata;
    logic                   ram_re;
    logic [ADDR_W-1:0]      ram_raddr;
    logic [SAMPLE_BITS-1:0] ram_rdata;
    seq_ctl_t               s1_ctl;
    logic [SAMPLE_BITS-1:0] s1_sample;
    logic [CNT_W-1:0]       s1_start;
    logic [CNT_W-1:0]       m_start;
    logic [SUM_W-1:0]       m_sum;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite
                 && (paddr[APB_ADDR_W-1:2] == REG_WINDOW_LEN);
    assign prdata = (paddr[APB_ADDR_W-1:2] == REG_WINDOW_LEN) ? APB_DATA_W'(len_reg) : '0;

    always_comb begin
        len_next = len_reg;
        if (cfg_we) begin
            len_next = pwdata[LEN_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= LEN_RESET;
        end else begin
            len_reg <= len_next;
        end
    end

    always_comb begin
        if (len_reg == '0) begin
            eff_len = EFF_W'(1);
        end else if (32'(len_reg) > WINDOW_MAX) begin
            eff_len = EFF_W'(WINDOW_MAX);
        end else begin
            eff_len = EFF_W'(len_reg);
        end
    end

    assign s_tready = advance;
    assign accept   = s_tvalid && advance;

    msw_seq #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clear     (cfg_we),
        .advance   (advance),
        .accept    (accept),
        .sample    (s_tdata[SAMPLE_BITS-1:0]),
        .last      (s_tlast),
        .eff_len   (eff_len),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .s1_ctl    (s1_ctl),
        .s1_sample (s1_sample),
        .s1_start  (s1_start)
    );

    msw_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_MAX)
    ) u_delay_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    msw_best #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_best (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clear     (cfg_we),
        .s1_ctl    (s1_ctl),
        .s1_sample (s1_sample),
        .s1_start  (s1_start),
        .rd_data   (ram_rdata),
        .m_tready  (m_tready),
        .advance   (advance),
        .m_valid   (m_tvalid),
        .m_start   (m_start),
        .m_sum     (m_sum)
    );

    assign m_tdata = OUT_W'({m_sum, m_start});

endmodule

### rtl/msw_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with a registered read port.
// Depends on nothing.
module msw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/msw_seq.sv
`timescale 1ns / 1ps
// Front stage: write pointer, sample counter and delay-line addressing.
// Depends on msw_pkg; drives the write and read ports of msw_ram.
module msw_seq #(
    parameter int WINDOW_MAX  = msw_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = msw_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = msw_pkg::COUNT_BITS_DEF,
    localparam int ADDR_W = $clog2(WINDOW_MAX),
    localparam int EFF_W  = $clog2(WINDOW_MAX + 1),
    localparam int CNT_W  = COUNT_BITS + 1
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   clear,
    input  logic                   advance,
    input  logic                   accept,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic                   last,
    input  logic [EFF_W-1:0]       eff_len,
    output logic                   ram_we,
    output logic [ADDR_W-1:0]      ram_waddr,
    output logic [SAMPLE_BITS-1:0] ram_wdata,
    output logic                   ram_re,
    output logic [ADDR_W-1:0]      ram_raddr,
    output msw_pkg::seq_ctl_t      s1_ctl,
    output logic [SAMPLE_BITS-1:0] s1_sample,
    output logic [CNT_W-1:0]       s1_start
);
    import msw_pkg::*;

    localparam int CALC_W = ADDR_W + 2;
    localparam logic [CALC_W-1:0] DEPTH_C = CALC_W'(WINDOW_MAX);
    localparam logic [ADDR_W-1:0] PTR_TOP = ADDR_W'(WINDOW_MAX - 1);

    logic [ADDR_W-1:0]      ptr_reg, ptr_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [CNT_W-1:0]       cnt_inc;
    logic [CNT_W-1:0]       start;
    logic [CALC_W-1:0]      back_sum;
    logic [ADDR_W-1:0]      old_addr;
    logic                   counted;
    logic                   sub_en;
    logic                   full;
    seq_ctl_t               s1_ctl_reg;
    logic [SAMPLE_BITS-1:0] s1_sample_reg;
    logic [CNT_W-1:0]       s1_start_reg;

    assign counted  = !cnt_reg[CNT_W-1];
    assign cnt_inc  = cnt_reg + 1'b1;
    assign sub_en   = 32'(cnt_reg) >= 32'(eff_len);
    assign full     = 32'(cnt_inc) >= 32'(eff_len);
    assign start    = cnt_inc - CNT_W'(eff_len) + 1'b1;
    assign back_sum = CALC_W'(ptr_reg) + DEPTH_C - CALC_W'(eff_len);
    assign old_addr = (back_sum >= DEPTH_C) ? ADDR_W'(back_sum - DEPTH_C)
                                            : ADDR_W'(back_sum);

    assign ram_we    = accept && counted;
    assign ram_waddr = ptr_reg;
    assign ram_wdata = sample;
    assign ram_re    = accept && counted && sub_en;
    assign ram_raddr = old_addr;

    always_comb begin
        ptr_next = ptr_reg;
        cnt_next = cnt_reg;
        if (clear) begin
            ptr_next = '0;
            cnt_next = '0;
        end else if (accept) begin
            if (last) begin
                ptr_next = '0;
                cnt_next = '0;
            end else if (counted) begin
                ptr_next = (ptr_reg == PTR_TOP) ? '0 : ptr_reg + 1'b1;
                cnt_next = cnt_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg    <= '0;
            cnt_reg    <= '0;
            s1_ctl_reg <= '0;
        end else begin
            ptr_reg <= ptr_next;
            cnt_reg <= cnt_next;
            if (advance) begin
                s1_ctl_reg.valid   <= accept;
                s1_ctl_reg.last    <= last;
                s1_ctl_reg.counted <= counted;
                s1_ctl_reg.sub_en  <= sub_en;
                s1_ctl_reg.full    <= full;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_sample_reg <= sample;
            s1_start_reg  <= start;
        end
    end

    assign s1_ctl    = s1_ctl_reg;
    assign s1_sample = s1_sample_reg;
    assign s1_start  = s1_start_reg;

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && last |=> (cnt_reg == '0) && (ptr_reg == '0))
        else $error("sequence state not cleared after final beat");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !last && !clear && counted |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("sample counter did not advance on a counted beat");

endmodule

### rtl/msw_best.sv
`timescale 1ns / 1ps
// Back stages: running window sum, best-window tracking and result register.
// Depends on msw_pkg; takes the delay-line read data from msw_ram.
module msw_best #(
    parameter int WINDOW_MAX  = msw_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = msw_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = msw_pkg::COUNT_BITS_DEF,
    localparam int CNT_W = COUNT_BITS + 1,
    localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW_MAX)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   clear,
    input  msw_pkg::seq_ctl_t      s1_ctl,
    input  logic [SAMPLE_BITS-1:0] s1_sample,
    input  logic [CNT_W-1:0]       s1_start,
    input  logic [SAMPLE_BITS-1:0] rd_data,
    input  logic                   m_tready,
    output logic                   advance,
    output logic                   m_valid,
    output logic [CNT_W-1:0]       m_start,
    output logic [SUM_W-1:0]       m_sum
);
    import msw_pkg::*;

    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [SUM_W-1:0] sum_calc;
    seq_ctl_t         s2_ctl_reg;
    logic [SUM_W-1:0] s2_sum_reg;
    logic [CNT_W-1:0] s2_start_reg;
    logic [SUM_W-1:0] best_val_reg, best_val_next, best_val_new;
    logic [CNT_W-1:0] best_idx_reg, best_idx_next, best_idx_new;
    logic             take;
    logic             fire;
    logic             m_valid_reg, m_valid_next;
    logic [CNT_W-1:0] m_start_reg;
    logic [SUM_W-1:0] m_sum_reg;

    assign advance = !(s2_ctl_reg.valid && s2_ctl_reg.last && m_valid_reg && !m_tready);

    always_comb begin
        sum_calc = sum_reg;
        if (s1_ctl.counted) begin
            sum_calc = sum_reg + SUM_W'(s1_sample)
                     - (s1_ctl.sub_en ? SUM_W'(rd_data) : '0);
        end
        sum_next = sum_reg;
        if (clear) begin
            sum_next = '0;
        end else if (advance && s1_ctl.valid) begin
            sum_next = s1_ctl.last ? '0 : sum_calc;
        end
    end

    assign take = s2_ctl_reg.valid && s2_ctl_reg.counted && s2_ctl_reg.full
               && ((best_idx_reg == '0) || (s2_sum_reg < best_val_reg));
    assign best_val_new = take ? s2_sum_reg : best_val_reg;
    assign best_idx_new = take ? s2_start_reg : best_idx_reg;
    assign fire = advance && s2_ctl_reg.valid && s2_ctl_reg.last;

    always_comb begin
        best_val_next = best_val_reg;
        best_idx_next = best_idx_reg;
        if (clear || fire) begin
            best_val_next = '1;
            best_idx_next = '0;
        end else if (advance) begin
            best_val_next = best_val_new;
            best_idx_next = best_idx_new;
        end
        m_valid_next = m_valid_reg;
        if (fire) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg      <= '0;
            best_val_reg <= '1;
            best_idx_reg <= '0;
            s2_ctl_reg   <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            sum_reg      <= sum_next;
            best_val_reg <= best_val_next;
            best_idx_reg <= best_idx_next;
            m_valid_reg  <= m_valid_next;
            if (advance) begin
                s2_ctl_reg <= s1_ctl;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && s1_ctl.valid) begin
            s2_sum_reg   <= sum_calc;
            s2_start_reg <= s1_start;
        end
        if (fire) begin
            if (best_idx_new == '0) begin
                m_start_reg <= '0;
                m_sum_reg   <= '0;
            end else begin
                m_start_reg <= best_idx_new;
                m_sum_reg   <= best_val_new;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_start = m_start_reg;
    assign m_sum   = m_sum_reg;

    a_final_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_valid_reg)
        else $error("final beat left no result");

    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_start_reg == '0) |-> (m_sum_reg == '0))
        else $error("result without a window carries a nonzero sum");

endmodule
